/* rtl/core/ordered_list_table_engine_top_macros.svh */
// assertion macros shared by the ordered list table engine rtl
// each macro expects clk and rst to be visible at the point of use
`ifndef ORDERED_LIST_TABLE_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_TABLE_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define OLTE_ASSERT_IMPL(name, ant, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define OLTE_ASSERT_NEXT(name, ant, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/core/olte_pkg.sv */
// shared types, constants and helpers for the ordered list table engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int TREE       = 1 << IDX_W;

  localparam int ACT_W  = 4;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 7;
  localparam int LEN_W  = 7;

  localparam logic [FIDX_W-1:0] NONE_INDEX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND     = 4'd0,
    ACT_INSERT     = 4'd1,
    ACT_REMOVE_VAL = 4'd2,
    ACT_REMOVE_AT  = 4'd3,
    ACT_CONTAINS   = 4'd4,
    ACT_FIRST_IDX  = 4'd5,
    ACT_LAST_IDX   = 4'd6,
    ACT_READ       = 4'd7,
    ACT_COUNT      = 4'd8,
    ACT_CLEAR      = 4'd9
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                  eval;
    logic                  ins;
    logic                  del;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      cnt;
    logic [VALUE_BITS-1:0] key;
  } cell_ctl_t;

  // sign extend the 32-bit word, then keep the stored width
  function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [DATA_W-1:0] v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[VALUE_BITS-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/olte_cell.sv */
// one list entry of the cell chain: compare, read select and shift
// depends on olte_pkg
`timescale 1ns / 1ps
`default_nettype none

module olte_cell import olte_pkg::*; (
  input  wire                   clk,
  input  wire [IDX_W-1:0]       idx,
  input  wire cell_ctl_t        ctl,
  input  wire [VALUE_BITS-1:0]  prev_value,
  input  wire [VALUE_BITS-1:0]  next_value,
  output logic [VALUE_BITS-1:0] value,
  output logic                  match,
  output logic [VALUE_BITS-1:0] rd_value
);

  logic [CNT_W-1:0] my_idx;

  assign my_idx = CNT_W'(idx);

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      match    <= (value == ctl.key) && (my_idx < ctl.cnt);
      rd_value <= (my_idx == ctl.pos) ? value : '0;
    end
    if (ctl.ins) begin
      // open a gap at pos, everything above moves up one
      if (my_idx > ctl.pos) begin
        value <= prev_value;
      end else if (my_idx == ctl.pos) begin
        value <= ctl.key;
      end
    end else if (ctl.del) begin
      if (my_idx >= ctl.pos) begin
        value <= next_value;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/olte_prio.sv */
// first and last match index over the cell match flags, as a binary tree
// depends on olte_pkg
`timescale 1ns / 1ps
`default_nettype none

module olte_prio import olte_pkg::*; (
  input  wire [DEPTH-1:0]  match,
  output logic             any,
  output logic [IDX_W-1:0] first,
  output logic [IDX_W-1:0] last
);

  logic [TREE-1:0]  padded;
  logic             any_h   [1:2*TREE-1];
  logic [IDX_W-1:0] first_h [1:2*TREE-1];
  logic [IDX_W-1:0] last_h  [1:2*TREE-1];

  assign padded = TREE'(match);

  always_comb begin
    for (int i = 0; i < TREE; i++) begin
      any_h[TREE+i]   = padded[i];
      first_h[TREE+i] = IDX_W'(i);
      last_h[TREE+i]  = IDX_W'(i);
    end
    for (int n = TREE - 1; n >= 1; n--) begin
      any_h[n]   = any_h[2*n] | any_h[2*n+1];
      first_h[n] = any_h[2*n] ? first_h[2*n] : first_h[2*n+1];
      last_h[n]  = any_h[2*n+1] ? last_h[2*n+1] : last_h[2*n];
    end
  end

  assign any   = any_h[1];
  assign first = first_h[1];
  assign last  = last_h[1];

endmodule

`default_nettype wire

/* rtl/core/ordered_list_table_engine_top.sv */
// channel  dir  handshake              payload
// s        in   s_tvalid / s_tready    tuser: action; tdata: position, item_value
// m        out  m_tvalid / m_tready    tuser: status; tdata: found_index, read_value,
//                                      list_length
//
// each request passes the eval state, for the cell compare and read select, and then
// the apply state, for the match tree, shift and result load; a new request is taken
// while idle or in the apply cycle. the output register lets a result wait while the
// next request is taken; the apply cycle holds until that register is free.
// rst is synchronous: length, state and output valid clear, entries are left as is.
//
// top level of the ordered list table engine; uses olte_pkg, olte_cell, olte_prio
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_table_engine_top_macros.svh"

module ordered_list_table_engine_top import olte_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // [6:0] position, [38:7] item_value, [39] zero
  input  wire  [3:0]  s_tuser,   // [3:0] action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // [6:0] found_index, [38:7] read_value,
                                 // [45:39] list_length, [47:46] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state, state_next;

  act_t                  req_act;
  logic [CNT_W-1:0]      req_pos;
  logic [VALUE_BITS-1:0] req_key;
  logic [CNT_W-1:0]      count, count_next;

  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [VALUE_BITS-1:0] cell_rd    [DEPTH];
  logic [VALUE_BITS-1:0] prev_w     [DEPTH];
  logic [VALUE_BITS-1:0] next_w     [DEPTH];
  logic [DEPTH-1:0]      match;
  cell_ctl_t             ctl;

  logic             hit_any;
  logic [IDX_W-1:0] hit_first;
  logic [IDX_W-1:0] hit_last;

  logic                  accept, out_free, apply_go, full;
  logic                  do_ins, do_del;
  logic [CNT_W-1:0]      op_pos;
  logic [VALUE_BITS-1:0] rd_or;
  status_t               res_status;
  logic [FIDX_W-1:0]     res_idx;
  logic [DATA_W-1:0]     res_value;

  assign out_free = !m_tvalid || m_tready;
  assign apply_go = (state == S_APPLY) && out_free;
  assign s_tready = (state == S_IDLE) || apply_go;
  assign accept   = s_tvalid && s_tready;
  assign full     = count >= CNT_W'(DEPTH);

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i] = '0;
    end else begin : g_mid
      assign prev_w[i] = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next_w[i] = '0;
    end else begin : g_inner
      assign next_w[i] = cell_value[i+1];
    end

    olte_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .prev_value (prev_w[i]),
      .next_value (next_w[i]),
      .value      (cell_value[i]),
      .match      (match[i]),
      .rd_value   (cell_rd[i])
    );
  end

  olte_prio u_prio (
    .match (match),
    .any   (hit_any),
    .first (hit_first),
    .last  (hit_last)
  );

  // only the addressed cell holds a nonzero read word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // ---- result and shift decode, used in the apply cycle ----
  always_comb begin
    res_status = ST_OK;
    res_idx    = NONE_INDEX;
    res_value  = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    op_pos     = req_pos;
    count_next = count;
    case (req_act)
      ACT_APPEND, ACT_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          op_pos     = (req_act == ACT_APPEND || req_pos > count) ? count : req_pos;
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE_VAL: begin
        if (hit_any) begin
          do_del     = 1'b1;
          op_pos     = CNT_W'(hit_first);
          res_idx    = FIDX_W'(hit_first);
          count_next = count - 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE_AT: begin
        if (req_pos >= count) begin
          res_status = ST_RANGE;
        end else begin
          do_del     = 1'b1;
          res_idx    = FIDX_W'(req_pos);
          res_value  = to_out(rd_or);
          count_next = count - 1'b1;
        end
      end
      ACT_CONTAINS: begin
        if (!hit_any) begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_FIRST_IDX: begin
        if (hit_any) begin
          res_idx = FIDX_W'(hit_first);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_LAST_IDX: begin
        if (hit_any) begin
          res_idx = FIDX_W'(hit_last);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (req_pos >= count) begin
          res_status = ST_RANGE;
        end else begin
          res_idx   = FIDX_W'(req_pos);
          res_value = to_out(rd_or);
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.eval = (state == S_EVAL);
    ctl.ins  = apply_go && do_ins;
    ctl.del  = apply_go && do_del;
    ctl.pos  = (state == S_EVAL) ? req_pos : op_pos;
    ctl.cnt  = count;
    ctl.key  = req_key;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_next = accept ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_act <= act_t'(s_tuser[ACT_W-1:0]);
      req_pos <= CNT_W'(s_tdata[POS_W-1:0]);
      req_key <= to_store(s_tdata[POS_W +: DATA_W]);
    end
    if (apply_go) begin
      m_tuser <= res_status;
      m_tdata <= {2'b00, LEN_W'(count_next), res_value, res_idx};
    end
  end

  `OLTE_ASSERT_IMPL(a_len_bound, 1'b1, count <= CNT_W'(DEPTH))
  `OLTE_ASSERT_NEXT(a_accept_eval, accept, state == S_EVAL)
  `OLTE_ASSERT_NEXT(a_eval_apply, state == S_EVAL, state == S_APPLY)
  `OLTE_ASSERT_NEXT(a_apply_loads, apply_go, m_tvalid)

endmodule

`default_nettype wire

/* test/tb.sv */
// self-checking testbench for ordered_list_table_engine_top: directed rows, then random phases
// a list mirror predicts each result word not fixed by a directed row; needs olte_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import olte_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 1725;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] idx;
    logic [DATA_W-1:0] rv;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                fixed;
    list_result_t      res;
  } stim_row_t;

  typedef enum int {MIX_FILL, MIX_QUERY, MIX_DRAIN, MIX_ANY} mix_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;   // [6:0] position, [38:7] item_value, [39] zero
  logic [3:0]  s_tuser  = '0;   // [3:0] action
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;         // [6:0] found_index, [38:7] read_value, [45:39] list_length
  wire  [1:0]  m_tuser;         // [1:0] status

  ordered_list_table_engine_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  logic [VALUE_BITS-1:0] list_mirror [DEPTH];
  int                    mirror_len = 0;
  list_result_t          pending_list_results [$];
  stim_row_t             directed_rows [$];
  bit                    row_is_fixed = 1'b0;
  list_result_t          row_result;
  bit                    calm = 1'b0;
  int                    error_count = 0;
  int                    idle_cycles = 0;
  bit                    progress;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int locate_entry(input logic [VALUE_BITS-1:0] key, input bit from_end);
    int hit;
    hit = -1;
    for (int i = 0; i < mirror_len; i++) begin
      if (list_mirror[i] == key && (from_end || hit < 0)) hit = i;
    end
    return hit;
  endfunction

  function automatic void drop_entry(input int at);
    for (int i = at; i + 1 < mirror_len; i++) list_mirror[i] = list_mirror[i + 1];
    mirror_len--;
  endfunction

  function automatic list_result_t apply_list_op(input logic [ACT_W-1:0] act,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] val);
    list_result_t          res;
    logic [VALUE_BITS-1:0] key;
    int                    hit;
    int                    at;
    key        = VALUE_BITS'(signed'(val));
    res.status = ST_OK;
    res.idx    = NONE_INDEX;
    res.rv     = '0;
    case (act)
      ACT_APPEND, ACT_INSERT: begin
        if (mirror_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // a position at or past the end appends
          at = (act == ACT_APPEND || int'(pos) > mirror_len) ? mirror_len : int'(pos);
          for (int i = mirror_len; i > at; i--) list_mirror[i] = list_mirror[i - 1];
          list_mirror[at] = key;
          mirror_len++;
        end
      end
      ACT_REMOVE_VAL: begin
        hit = locate_entry(key, 1'b0);
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          drop_entry(hit);
          res.idx = FIDX_W'(hit);
        end
      end
      ACT_REMOVE_AT, ACT_READ: begin
        if (int'(pos) >= mirror_len) begin
          res.status = ST_RANGE;
        end else begin
          res.rv  = DATA_W'(list_mirror[pos]);
          res.idx = pos;
          if (act == ACT_REMOVE_AT) drop_entry(int'(pos));
        end
      end
      ACT_CONTAINS: begin
        if (locate_entry(key, 1'b0) < 0) res.status = ST_NOT_FOUND;
      end
      ACT_FIRST_IDX, ACT_LAST_IDX: begin
        hit = locate_entry(key, act == ACT_LAST_IDX);
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.idx = FIDX_W'(hit);
      end
      ACT_CLEAR: begin
        mirror_len = 0;
      end
      default: begin
      end
    endcase
    res.len = LEN_W'(mirror_len);
    return res;
  endfunction

  // check result words, predict accepted request words, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (m_tvalid && m_tready) begin
        list_result_t want;
        progress = 1'b1;
        if (pending_list_results.size() == 0) begin
          report_mismatch("result word with nothing expected", m_tdata, '0);
        end else begin
          want = pending_list_results.pop_front();
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
          if (m_tdata[6:0] !== want.idx) report_mismatch("found_index", m_tdata[6:0], want.idx);
          if (m_tdata[38:7] !== want.rv) report_mismatch("read_value", m_tdata[38:7], want.rv);
          if (m_tdata[45:39] !== want.len)
            report_mismatch("list_length", m_tdata[45:39], want.len);
        end
      end
      if (s_tvalid && s_tready) begin
        list_result_t pred;
        progress = 1'b1;
        pred = apply_list_op(s_tuser, s_tdata[6:0], s_tdata[38:7]);
        pending_list_results.push_back(row_is_fixed ? row_result : pred);
      end
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, val, pos};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val, input bit fixed,
                         input logic [STAT_W-1:0] status, input logic [FIDX_W-1:0] idx,
                         input logic [DATA_W-1:0] rv, input logic [LEN_W-1:0] len);
    stim_row_t r;
    r.act        = act;
    r.pos        = pos;
    r.val        = val;
    r.fixed      = fixed;
    r.res.status = status;
    r.res.idx    = idx;
    r.res.rv     = rv;
    r.res.len    = len;
    directed_rows.push_back(r);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return (mirror_len > 0) ? DATA_W'(list_mirror[$urandom_range(mirror_len - 1)])
                                          : DATA_W'($urandom);
      4, 5:       return DATA_W'($urandom_range(5)) - 32'd2;
      6: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default:    return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return POS_W'($urandom_range(mirror_len));
      6, 7:             return POS_W'($urandom_range(127));
      8:                return (mirror_len > 0) ? POS_W'(mirror_len - 1) : '0;
      default:          return POS_W'(DEPTH);
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input mix_mode_t mode);
    int               r;
    logic [ACT_W-1:0] act;
    r   = $urandom_range(99);
    act = ACT_W'($urandom_range(15));
    case (mode)
      MIX_FILL: begin
        if (r < 50) act = ACT_APPEND;
        else if (r < 85) act = ACT_INSERT;
        else if (r < 90) act = ACT_READ;
        else if (r < 95) act = (r < 93) ? ACT_FIRST_IDX : ACT_LAST_IDX;
      end
      MIX_DRAIN: begin
        if (r < 35) act = ACT_REMOVE_AT;
        else if (r < 65) act = ACT_REMOVE_VAL;
        else if (r < 75) act = ACT_READ;
        else if (r < 85) act = ACT_APPEND;
      end
      MIX_QUERY: begin
        if (r < 20) act = ACT_CONTAINS;
        else if (r < 40) act = ACT_FIRST_IDX;
        else if (r < 60) act = ACT_LAST_IDX;
        else if (r < 80) act = ACT_READ;
        else if (r < 88) act = ACT_COUNT;
        else if (r < 95) act = ACT_APPEND;
      end
      default: begin
      end
    endcase
    // keep clears rare so the list has time to fill
    if (act == ACT_CLEAR && $urandom_range(3) != 0) act = ACT_COUNT;
    return act;
  endfunction

  initial begin
    int               sent;
    int               round;
    int               round_len;
    mix_mode_t        mode;
    logic [ACT_W-1:0] act;

    // empty list, then entries at the value extremes, reads, searches, removes, unused codes, clear
    add_row(ACT_COUNT,      7'd0,   32'h0,         1, ST_OK,        NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_READ,       7'd0,   32'h0,         1, ST_RANGE,     NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_REMOVE_AT,  7'd127, 32'h0,         1, ST_RANGE,     NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_CONTAINS,   7'd0,   32'h0,         1, ST_NOT_FOUND, NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_REMOVE_VAL, 7'd0,   32'h0,         1, ST_NOT_FOUND, NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_FIRST_IDX,  7'd0,   32'h0,         1, ST_NOT_FOUND, NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_LAST_IDX,   7'd0,   32'h0,         1, ST_NOT_FOUND, NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_INSERT,     7'd5,   32'h7fff_ffff, 1, ST_OK,        NONE_INDEX, 32'h0, 7'd1);
    add_row(ACT_APPEND,     7'd0,   32'h8000_0000, 1, ST_OK,        NONE_INDEX, 32'h0, 7'd2);
    add_row(ACT_APPEND,     7'd0,   32'hffff_ffff, 1, ST_OK,        NONE_INDEX, 32'h0, 7'd3);
    add_row(ACT_INSERT,     7'd127, 32'h0,         1, ST_OK,        NONE_INDEX, 32'h0, 7'd4);
    add_row(ACT_INSERT,     7'd0,   32'hffff_ffff, 1, ST_OK,        NONE_INDEX, 32'h0, 7'd5);
    add_row(ACT_READ,       7'd0,   32'h0,         1, ST_OK,        7'd0, 32'hffff_ffff, 7'd5);
    add_row(ACT_READ,       7'd4,   32'h0,         1, ST_OK,        7'd4, 32'h0,         7'd5);
    add_row(ACT_READ,       7'd5,   32'h0,         1, ST_RANGE,     NONE_INDEX, 32'h0, 7'd5);
    add_row(ACT_FIRST_IDX,  7'd0,   32'hffff_ffff, 0, '0, '0, '0, '0);
    add_row(ACT_LAST_IDX,   7'd0,   32'hffff_ffff, 0, '0, '0, '0, '0);
    add_row(ACT_CONTAINS,   7'd0,   32'h8000_0000, 0, '0, '0, '0, '0);
    add_row(ACT_REMOVE_VAL, 7'd0,   32'hffff_ffff, 0, '0, '0, '0, '0);
    add_row(ACT_REMOVE_AT,  7'd1,   32'h0,         0, '0, '0, '0, '0);
    add_row(4'd10,          7'd127, 32'hffff_ffff, 0, '0, '0, '0, '0);
    add_row(4'd15,          7'd0,   32'h0,         0, '0, '0, '0, '0);
    add_row(ACT_COUNT,      7'd0,   32'h0,         0, '0, '0, '0, '0);
    add_row(ACT_CLEAR,      7'd0,   32'h0,         1, ST_OK,        NONE_INDEX, 32'h0, 7'd0);
    add_row(ACT_COUNT,      7'd0,   32'h0,         1, ST_OK,        NONE_INDEX, 32'h0, 7'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row_is_fixed = directed_rows[i].fixed;
      row_result   = directed_rows[i].res;
      send_word(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val);
    end
    row_is_fixed = 1'b0;

    sent  = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      // hold off until every result word of the last round has drained
      s_tvalid <= 1'b0;
      @(negedge clk);
      while (pending_list_results.size() != 0) @(negedge clk);
      calm      = (round == 6);
      mode      = mix_mode_t'(round % 4);
      round_len = calm ? 250 : $urandom_range(60, 140);
      for (int k = 0; k < round_len && sent < RANDOM_ITEMS; k++) begin
        act = pick_action(mode);
        send_word(act, pick_position(), pick_value());
        sent++;
      end
      round++;
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
